### sv/mfde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

  // Default panel geometry.
  localparam int DEF_PANEL_COLUMNS    = 250;
  localparam int DEF_PANEL_ROWS       = 122;
  localparam int DEF_BYTES_PER_COLUMN = 16;

  // Width of the signed position fields on the input side.
  localparam int XY_W = 11;

  // Internal signed coordinate width. It covers every corner that a rectangle
  // or a scaled glyph can reach from an 11-bit origin.
  localparam int COORD_W = 13;

  // Glyph rows are eight bits wide, so the last column has index seven.
  localparam logic [2:0] GLYPH_LAST_COL = 3'd7;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_RECT  = 2'd1,
    MODE_GLYPH = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PK_FILL = 2'd0,
    PK_READ = 2'd1,
    PK_HSEG = 2'd2,
    PK_VSEG = 2'd3
  } plot_kind_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [XY_W-1:0]  x_pos;
    logic signed [XY_W-1:0]  y_pos;
    logic [9:0]              width;
    logic [9:0]              height;
    logic [7:0]              thickness;
    logic [3:0]              row_index;
    logic [7:0]              row_bits;
    logic [7:0]              fill_byte;
    logic [11:0]             read_index;
  } draw_item_t;

  // One command to the plot unit: a fill sweep, a byte read, or a line
  // segment at a fixed row (HSEG) or column (VSEG) over [lo, hi).
  typedef struct packed {
    plot_kind_t                kind;
    logic signed [COORD_W-1:0] fixed;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic [7:0]                fill;
    logic [11:0]               index;
  } plot_cmd_t;

endpackage

`default_nettype wire

### sv/mfde_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mfde_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4000,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/mfde_plot.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared plot unit. It owns the frame store and runs one command at a time:
// a fill sweep, a byte read, or a clipped line segment plotted pixel by pixel
// with a read-modify-write for each pixel.
module mfde_plot #(
  parameter int PANEL_COLUMNS    = mfde_pkg::DEF_PANEL_COLUMNS,
  parameter int PANEL_ROWS       = mfde_pkg::DEF_PANEL_ROWS,
  parameter int BYTES_PER_COLUMN = mfde_pkg::DEF_BYTES_PER_COLUMN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  mfde_pkg::plot_cmd_t cmd,
  output logic                ready,
  output logic [7:0]          rd_data
);

  localparam int STORE_BYTES = PANEL_COLUMNS * BYTES_PER_COLUMN;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int ROW_LIMIT   = (PANEL_ROWS < 8 * BYTES_PER_COLUMN) ? PANEL_ROWS
                                                                  : 8 * BYTES_PER_COLUMN;
  localparam int CW          = mfde_pkg::COORD_W;

  localparam logic signed [CW-1:0] COL_LIM = CW'(PANEL_COLUMNS);
  localparam logic signed [CW-1:0] ROW_LIM = CW'(ROW_LIMIT);
  localparam logic signed [CW-1:0] ONE     = CW'(1);
  localparam logic [AW-1:0]        LAST    = AW'(STORE_BYTES - 1);

  typedef enum logic [2:0] {
    P_IDLE,
    P_FILL,
    P_READ,
    P_CLIP,
    P_RD,
    P_WR
  } state_t;

  state_t               state;
  logic                 horiz;
  logic signed [CW-1:0] seg_fixed;
  logic signed [CW-1:0] seg_pos;
  logic signed [CW-1:0] seg_end;
  logic [7:0]           fill_q;
  logic [AW-1:0]        sweep;
  logic [AW-1:0]        pix_addr;
  logic [7:0]           pix_mask;

  logic signed [CW-1:0] fix_lim;
  logic signed [CW-1:0] run_lim;
  logic                 fix_ok;
  logic signed [CW-1:0] lo_c;
  logic signed [CW-1:0] hi_c;
  logic [CW-1:0]        col;
  logic [CW-1:0]        row;
  logic [AW-1:0]        pix_addr_c;
  logic [7:0]           pix_mask_c;
  logic                 in_range;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_q;

  // Clipping of a segment against the panel and the byte rows of a column.
  assign fix_lim = horiz ? ROW_LIM : COL_LIM;
  assign run_lim = horiz ? COL_LIM : ROW_LIM;
  assign fix_ok  = !seg_fixed[CW-1] && (seg_fixed < fix_lim);
  assign lo_c    = seg_pos[CW-1] ? '0 : seg_pos;
  assign hi_c    = (seg_end > run_lim) ? run_lim : seg_end;

  // Address and bit of the current pixel. After clipping both are in range.
  assign col        = horiz ? seg_pos : seg_fixed;
  assign row        = horiz ? seg_fixed : seg_pos;
  assign pix_addr_c = AW'(col * BYTES_PER_COLUMN) + AW'(row >> 3);
  assign pix_mask_c = 8'h80 >> row[2:0];

  assign in_range = 32'(cmd.index) < 32'(STORE_BYTES);

  assign ready     = (state == P_IDLE);
  assign ram_we    = (state == P_FILL) || (state == P_WR);
  assign ram_waddr = (state == P_FILL) ? sweep : pix_addr;
  assign ram_wdata = (state == P_FILL) ? fill_q : (ram_q & ~pix_mask);
  assign ram_raddr = (state == P_RD) ? pix_addr_c : AW'(cmd.index);

  mfde_ram #(
    .WIDTH  (8),
    .DEPTH  (STORE_BYTES),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      unique case (state)
        P_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              mfde_pkg::PK_FILL: begin
                sweep  <= '0;
                fill_q <= cmd.fill;
                state  <= P_FILL;
              end
              mfde_pkg::PK_READ: begin
                if (in_range) begin
                  state <= P_READ;
                end else begin
                  rd_data <= '0;
                end
              end
              mfde_pkg::PK_HSEG, mfde_pkg::PK_VSEG: begin
                horiz     <= (cmd.kind == mfde_pkg::PK_HSEG);
                seg_fixed <= cmd.fixed;
                seg_pos   <= cmd.lo;
                seg_end   <= cmd.hi;
                state     <= P_CLIP;
              end
            endcase
          end
        end
        P_FILL: begin
          if (sweep == LAST) begin
            state <= P_IDLE;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end
        P_READ: begin
          rd_data <= ram_q;
          state   <= P_IDLE;
        end
        P_CLIP: begin
          if (fix_ok && (lo_c < hi_c)) begin
            seg_pos <= lo_c;
            seg_end <= hi_c;
            state   <= P_RD;
          end else begin
            state <= P_IDLE;
          end
        end
        P_RD: begin
          pix_addr <= pix_addr_c;
          pix_mask <= pix_mask_c;
          state    <= P_WR;
        end
        P_WR: begin
          if (seg_pos == seg_end - ONE) begin
            state <= P_IDLE;
          end else begin
            seg_pos <= seg_pos + ONE;
            state   <= P_RD;
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/mfde_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Command sequencer. It breaks one transaction into plot unit commands:
// a single fill or read, up to four outline segments per thickness step, or one
// horizontal segment per scaled row of each set glyph bit.
module mfde_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  mfde_pkg::draw_item_t item,
  input  logic [3:0]           glyph_scale,
  input  logic                 plot_ready,
  output logic                 cmd_valid,
  output mfde_pkg::plot_cmd_t  cmd,
  output logic                 idle
);

  localparam int CW = mfde_pkg::COORD_W;
  localparam int XW = mfde_pkg::XY_W;

  localparam logic signed [CW-1:0] ONE = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_RECT,
    S_GLYPH
  } state_t;

  state_t               state;
  mfde_pkg::draw_item_t item_q;
  logic [7:0]           t;
  logic [1:0]           ph;
  logic [2:0]           gcol;
  logic [3:0]           sy;
  logic [7:0]           bits_q;
  logic signed [CW-1:0] col_base;
  logic signed [CW-1:0] row_base;

  logic [7:0]           row_off;
  logic signed [CW-1:0] row_off_s;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] ws;
  logic signed [CW-1:0] hs;
  logic signed [CW-1:0] ts;
  logic signed [CW-1:0] sys;
  logic signed [CW-1:0] scl;
  logic                 hor;
  logic                 ver;
  logic                 rect_done;
  logic                 seg_ok;
  logic                 last_sy;
  mfde_pkg::plot_kind_t seg_kind;
  logic signed [CW-1:0] seg_fixed;
  logic signed [CW-1:0] seg_lo;
  logic signed [CW-1:0] seg_hi;

  // Glyph row origin, taken from the ports at the start of the transaction.
  assign row_off   = {4'd0, item.row_index} * {4'd0, glyph_scale};
  assign row_off_s = CW'({1'b0, row_off});
  assign start_x   = {{(CW - XW){item.x_pos[XW-1]}}, item.x_pos};
  assign start_y   = {{(CW - XW){item.y_pos[XW-1]}}, item.y_pos};

  assign xs  = {{(CW - XW){item_q.x_pos[XW-1]}}, item_q.x_pos};
  assign ys  = {{(CW - XW){item_q.y_pos[XW-1]}}, item_q.y_pos};
  assign ws  = CW'({1'b0, item_q.width});
  assign hs  = CW'({1'b0, item_q.height});
  assign ts  = CW'({1'b0, t});
  assign sys = CW'({1'b0, sy});
  assign scl = CW'({1'b0, glyph_scale});

  // A step draws its rows while twice the step is below the width, and its
  // columns while twice the step is below the height.
  assign hor       = {1'b0, t, 1'b0} < item_q.width;
  assign ver       = {1'b0, t, 1'b0} < item_q.height;
  assign rect_done = (t == item_q.thickness) || (!hor && !ver);
  assign last_sy   = (sy == glyph_scale - 4'd1);

  always_comb begin
    seg_kind  = mfde_pkg::PK_HSEG;
    seg_fixed = ys + ts;
    seg_lo    = xs + ts;
    seg_hi    = xs + ws - ts;
    seg_ok    = hor;
    if (state == S_GLYPH) begin
      seg_fixed = row_base + sys;
      seg_lo    = col_base;
      seg_hi    = col_base + scl;
      seg_ok    = bits_q[7];
    end else begin
      unique case (ph)
        2'd0: begin
          seg_fixed = ys + ts;
        end
        2'd1: begin
          seg_fixed = ys + hs - ts - ONE;
        end
        2'd2: begin
          seg_kind  = mfde_pkg::PK_VSEG;
          seg_fixed = xs + ts;
          seg_lo    = ys + ts;
          seg_hi    = ys + hs - ts;
          seg_ok    = ver;
        end
        2'd3: begin
          seg_kind  = mfde_pkg::PK_VSEG;
          seg_fixed = xs + ws - ts - ONE;
          seg_lo    = ys + ts;
          seg_hi    = ys + hs - ts;
          seg_ok    = ver;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.fixed = seg_fixed;
    cmd.lo    = seg_lo;
    cmd.hi    = seg_hi;
    cmd.fill  = item_q.fill_byte;
    cmd.index = item_q.read_index;
    cmd.kind  = seg_kind;
    cmd_valid = 1'b0;
    unique case (state)
      S_SINGLE: begin
        cmd.kind  = (item_q.mode == mfde_pkg::MODE_CLEAR) ? mfde_pkg::PK_FILL
                                                          : mfde_pkg::PK_READ;
        cmd_valid = 1'b1;
      end
      S_RECT:  cmd_valid = !rect_done && seg_ok;
      S_GLYPH: cmd_valid = (glyph_scale != 4'd0) && seg_ok;
      default: cmd_valid = 1'b0;
    endcase
  end

  assign idle = (state == S_IDLE) && plot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q   <= item;
            t        <= '0;
            ph       <= '0;
            gcol     <= '0;
            sy       <= '0;
            bits_q   <= item.row_bits;
            col_base <= start_x;
            row_base <= start_y + row_off_s;
            unique case (item.mode)
              mfde_pkg::MODE_RECT:  state <= S_RECT;
              mfde_pkg::MODE_GLYPH: state <= S_GLYPH;
              default:              state <= S_SINGLE;
            endcase
          end
        end
        S_SINGLE: begin
          if (plot_ready) begin
            state <= S_IDLE;
          end
        end
        S_RECT: begin
          if (rect_done) begin
            state <= S_IDLE;
          end else if (!seg_ok || plot_ready) begin
            ph <= ph + 2'd1;
            if (ph == 2'd3) begin
              t <= t + 8'd1;
            end
          end
        end
        S_GLYPH: begin
          if (glyph_scale == 4'd0) begin
            state <= S_IDLE;
          end else if (!bits_q[7] || (plot_ready && last_sy)) begin
            bits_q   <= {bits_q[6:0], 1'b0};
            col_base <= col_base + scl;
            sy       <= '0;
            gcol     <= gcol + 3'd1;
            if (gcol == mfde_pkg::GLYPH_LAST_COL) begin
              state <= S_IDLE;
            end
          end else if (plot_ready) begin
            sy <= sy + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/mono_framebuffer_draw_engine.sv
// Operation: a clear sweeps every byte of the store; a read goes through the registered read
// of the store, or returns zero without a store read when the index is outside the store;
// rectangle and glyph row issue their line segments one after another and plot each visible
// pixel with a read-modify-write through the registered read of the store.
// Throughput: one transaction at a time; the next is taken when the current one ends.
// Reset clears the control state and sets glyph_scale to 1; the frame store is not
// cleared and must be written by a clear before it is read or drawn into.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_draw_engine #(
  parameter int PANEL_COLUMNS    = mfde_pkg::DEF_PANEL_COLUMNS,
  parameter int PANEL_ROWS       = mfde_pkg::DEF_PANEL_ROWS,
  parameter int BYTES_PER_COLUMN = mfde_pkg::DEF_BYTES_PER_COLUMN
) (
  input  logic        clk,
  input  logic        rst,

  // Configuration: the glyph scale register.
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,

  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic signed [10:0] x_pos,
  input  logic signed [10:0] y_pos,
  input  logic [9:0]  width,
  input  logic [9:0]  height,
  input  logic [7:0]  thickness,
  input  logic [3:0]  row_index,
  input  logic [7:0]  row_bits,
  input  logic [7:0]  fill_byte,
  input  logic [11:0] read_index,

  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        op_done
);

  // The engine is busy from the accepted transaction until its result moves
  // into the output register. The output register is separate, so a new
  // transaction is taken while a finished result still waits downstream.
  logic                 busy;
  mfde_pkg::mode_t      mode_q;
  logic [3:0]           glyph_scale;

  logic                 accept;
  logic                 finish;
  mfde_pkg::draw_item_t item;

  logic                 seq_cmd_valid;
  mfde_pkg::plot_cmd_t  seq_cmd;
  logic                 seq_idle;
  logic                 plot_ready;
  logic [7:0]           plot_rd_data;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // The engine is done when the sequencer has no more commands and the plot
  // unit has finished the last one. The result leaves only when the output
  // register is empty or being emptied in the same cycle.
  assign finish = busy && seq_idle && (!out_valid || !out_stall);

  always_comb begin
    item.mode       = mfde_pkg::mode_t'(mode);
    item.x_pos      = x_pos;
    item.y_pos      = y_pos;
    item.width      = width;
    item.height     = height;
    item.thickness  = thickness;
    item.row_index  = row_index;
    item.row_bits   = row_bits;
    item.fill_byte  = fill_byte;
    item.read_index = read_index;
  end

  // The sequencer turns each transaction into fill, read and segment commands.
  mfde_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .item        (item),
    .glyph_scale (glyph_scale),
    .plot_ready  (plot_ready),
    .cmd_valid   (seq_cmd_valid),
    .cmd         (seq_cmd),
    .idle        (seq_idle)
  );

  // The plot unit holds the frame store and is the one shared worker: it
  // clips each segment and clears one pixel bit per read-modify-write.
  mfde_plot #(
    .PANEL_COLUMNS    (PANEL_COLUMNS),
    .PANEL_ROWS       (PANEL_ROWS),
    .BYTES_PER_COLUMN (BYTES_PER_COLUMN)
  ) u_plot (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (seq_cmd_valid),
    .cmd       (seq_cmd),
    .ready     (plot_ready),
    .rd_data   (plot_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      glyph_scale <= 4'd1;
    end else begin
      if (cfg_wr_en) begin
        glyph_scale <= cfg_wr_data;
      end
      if (accept) begin
        busy   <= 1'b1;
        mode_q <= mfde_pkg::mode_t'(mode);
      end
      if (finish) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        // Only a read returns stored data; every other mode reports zero.
        read_data <= (mode_q == mfde_pkg::MODE_READ) ? plot_rd_data : 8'd0;
        op_done   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/mfde_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       op_done
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Transactions taken in but whose result has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input taken while a transaction is still in work");

  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> op_done)
    else $error("result shown without completion flag");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 2'd0))
    else $error("result shown without an accepted transaction");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two transactions outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data)))
    else $error("stalled result changed or dropped");

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);

`default_nettype wire
